/* hdl/lap3_pkg.sv */
// lap3_pkg: shared constants, types and helpers for the laplacian 3x3 edge filter
package lap3_pkg;

   localparam int PIX_W       = 8;
   localparam int COORD_W     = 11;
   localparam int DIM_W       = 12;
   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_HEIGHT  = 2048;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int WIDTH_LIMIT = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
   localparam int WIN_SIZE    = 3;
   localparam int WIN_TAPS    = WIN_SIZE * WIN_SIZE;
   localparam int NSUM_W      = PIX_W + 3;
   localparam int SUM_W       = PIX_W + 5;
   localparam int CSR_INDEX_W = 2;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
   localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(3);

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type lower;
   } line_pair_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      line_pair_type     wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } ram_ctrl_type;

   // index is row * 3 + column, row 0 oldest, column 2 newest
   typedef logic [WIN_TAPS-1:0][PIX_W-1:0] window_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                  input logic [DIM_W-1:0] limit);
      logic [DIM_W-1:0] result;
      result = value;
      if (result < DIM_MIN) begin
         result = DIM_MIN;
      end
      if (result > limit) begin
         result = limit;
      end
      return result;
   endfunction

endpackage

/* hdl/lap3_line_ram.sv */
// lap3_line_ram: paired line store memory, registered read
module lap3_line_ram import lap3_pkg::*; (
   input  logic          clock,
   input  ram_ctrl_type  ctrl,
   output line_pair_type rd_data
);

   line_pair_type mem [MAX_WIDTH];
   line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.we) begin
         mem[ctrl.waddr] <= ctrl.wdata;
      end
      if (ctrl.re) begin
         rd_data_ff <= mem[ctrl.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/lap3_kernel.sv */
// lap3_kernel: laplacian sum over the 3x3 window with clamp to pixel range
module lap3_kernel import lap3_pkg::*; (
   input  window_type window,
   output pixel_type  pixel_out
);

   localparam int CENTER = WIN_TAPS / 2;

   logic [NSUM_W-1:0]        nsum;
   logic signed [SUM_W-1:0]  total;
   logic [NSUM_W-1:0]        center8;

   always_comb begin
      nsum = '0;
      for (int k = 0; k < WIN_TAPS; k++) begin
         if (k != CENTER) begin
            nsum = nsum + NSUM_W'(window[k]);
         end
      end
      center8 = {window[CENTER], 3'b000};
      total   = signed'({2'b00, center8}) - signed'({2'b00, nsum});
      if (total < 0) begin
         pixel_out = '0;
      end else if (total > signed'(SUM_W'(255))) begin
         pixel_out = '1;
      end else begin
         pixel_out = total[PIX_W-1:0];
      end
   end

endmodule

/* hdl/laplacian_3x3_edge_filter.sv */
// laplacian_3x3_edge_filter: streaming 3x3 laplacian edge filter, top level
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   req     | req_valid req_ready req_pixel_in             | in
//   rsp     | rsp_valid rsp_ready rsp_pixel_out            | out
//           | rsp_out_column rsp_out_row rsp_frame_end     |
//   csr     | csr_write_enable csr_index csr_write_data    | in
//
// one pixel per cycle while the output is not stalled; a taken pixel passes
// the line store read, then the kernel into the output register
// the line store memory is read at accept and written back when that pixel leaves s1
// reset clears counters, window and valid flags; the line store is not cleared
// a stalled output holds the pipeline and drops req_ready only when full
module laplacian_3x3_edge_filter import lap3_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIX_W-1:0]       req_pixel_in,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PIX_W-1:0]       rsp_pixel_out,
   output logic [COORD_W-1:0]     rsp_out_column,
   output logic [COORD_W-1:0]     rsp_out_row,
   output logic                   rsp_frame_end,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]       csr_write_data
);

   logic [DIM_W-1:0]   image_width_ff, image_width_in;
   logic [DIM_W-1:0]   image_height_ff, image_height_in;
   logic [COORD_W-1:0] column_count_ff, column_count_in;
   logic [COORD_W-1:0] row_count_ff, row_count_in;

   logic               s1_valid_ff, s1_valid_in;
   pixel_type          s1_pixel_ff, s1_pixel_in;
   logic [ADDR_W-1:0]  s1_addr_ff, s1_addr_in;
   logic               s1_in_store_ff, s1_in_store_in;
   logic               s1_produce_ff, s1_produce_in;
   logic               s1_last_ff, s1_last_in;
   logic [COORD_W-1:0] s1_column_ff, s1_column_in;
   logic [COORD_W-1:0] s1_row_ff, s1_row_in;

   pixel_type [WIN_SIZE-1:0] win_mid_ff, win_mid_in;
   pixel_type [WIN_SIZE-1:0] win_new_ff, win_new_in;

   logic               rsp_valid_ff, rsp_valid_in;
   pixel_type          rsp_pixel_ff, rsp_pixel_in;
   logic [COORD_W-1:0] rsp_column_ff, rsp_column_in;
   logic [COORD_W-1:0] rsp_row_ff, rsp_row_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [DIM_W-1:0]   eff_width;
   logic [DIM_W-1:0]   eff_height;
   logic [DIM_W-1:0]   col_ext;
   logic [DIM_W-1:0]   row_ext;
   logic               accept;
   logic               s1_adv;
   logic               in_store;
   ram_ctrl_type       ram_ctrl;
   line_pair_type      ram_rd;
   pixel_type [WIN_SIZE-1:0] new_col;
   window_type         window;
   pixel_type          filtered;

   assign eff_width  = clamp_dim(image_width_ff, DIM_W'(WIDTH_LIMIT));
   assign eff_height = clamp_dim(image_height_ff, DIM_W'(MAX_HEIGHT));
   assign col_ext    = {1'b0, column_count_ff};
   assign row_ext    = {1'b0, row_count_ff};

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign accept    = req_valid && req_ready;
   assign in_store  = (32'(column_count_ff) < MAX_WIDTH);

   // new window column: row r-2, row r-1, current pixel
   always_comb begin
      new_col[0] = s1_in_store_ff ? ram_rd.upper : '0;
      new_col[1] = s1_in_store_ff ? ram_rd.lower : '0;
      new_col[2] = s1_pixel_ff;
      for (int r = 0; r < WIN_SIZE; r++) begin
         window[r * WIN_SIZE + 0] = win_mid_ff[r];
         window[r * WIN_SIZE + 1] = win_new_ff[r];
         window[r * WIN_SIZE + 2] = new_col[r];
      end
   end

   always_comb begin
      ram_ctrl.re          = accept && in_store;
      ram_ctrl.raddr       = column_count_ff[ADDR_W-1:0];
      ram_ctrl.we          = s1_adv && s1_in_store_ff;
      ram_ctrl.waddr       = s1_addr_ff;
      ram_ctrl.wdata.upper = new_col[1];
      ram_ctrl.wdata.lower = s1_pixel_ff;
   end

   lap3_line_ram u_line_ram (
      .clock   (clock),
      .ctrl    (ram_ctrl),
      .rd_data (ram_rd)
   );

   lap3_kernel u_kernel (
      .window    (window),
      .pixel_out (filtered)
   );

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_in  = csr_write_data;
            CSR_IMAGE_HEIGHT: image_height_in = csr_write_data;
            default:          ;
         endcase
      end
   end

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      s1_valid_in     = s1_valid_ff;
      s1_pixel_in     = s1_pixel_ff;
      s1_addr_in      = s1_addr_ff;
      s1_in_store_in  = s1_in_store_ff;
      s1_produce_in   = s1_produce_ff;
      s1_last_in      = s1_last_ff;
      s1_column_in    = s1_column_ff;
      s1_row_in       = s1_row_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in    = 1'b1;
         s1_pixel_in    = req_pixel_in;
         s1_addr_in     = column_count_ff[ADDR_W-1:0];
         s1_in_store_in = in_store;
         s1_produce_in  = (column_count_ff >= COORD_W'(2)) && (row_count_ff >= COORD_W'(2))
                          && (col_ext < eff_width) && (row_ext < eff_height);
         s1_last_in     = (col_ext == eff_width - DIM_W'(1))
                          && (row_ext == eff_height - DIM_W'(1));
         s1_column_in   = column_count_ff - COORD_W'(1);
         s1_row_in      = row_count_ff - COORD_W'(1);
         if (col_ext + DIM_W'(1) >= eff_width) begin
            column_count_in = '0;
            if (row_ext + DIM_W'(1) >= eff_height) begin
               row_count_in = '0;
            end else begin
               row_count_in = row_count_ff + COORD_W'(1);
            end
         end else begin
            column_count_in = column_count_ff + COORD_W'(1);
         end
      end
   end

   always_comb begin
      win_mid_in    = win_mid_ff;
      win_new_in    = win_new_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_column_in = rsp_column_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_adv) begin
         win_mid_in   = win_new_ff;
         win_new_in   = new_col;
         rsp_valid_in = s1_produce_ff;
         if (s1_produce_ff) begin
            rsp_pixel_in  = filtered;
            rsp_column_in = s1_column_ff;
            rsp_row_in    = s1_row_ff;
            rsp_last_in   = s1_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_RESET;
         image_height_ff <= HEIGHT_RESET;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         win_mid_ff      <= '0;
         win_new_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         s1_valid_ff     <= s1_valid_in;
         win_mid_ff      <= win_mid_in;
         win_new_ff      <= win_new_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pixel_ff    <= s1_pixel_in;
      s1_addr_ff     <= s1_addr_in;
      s1_in_store_ff <= s1_in_store_in;
      s1_produce_ff  <= s1_produce_in;
      s1_last_ff     <= s1_last_in;
      s1_column_ff   <= s1_column_in;
      s1_row_ff      <= s1_row_in;
      rsp_pixel_ff   <= rsp_pixel_in;
      rsp_column_ff  <= rsp_column_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_ff;
   assign rsp_out_column = rsp_column_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_frame_end  = rsp_last_ff;

endmodule

/* hdl/lap3_checker.sv */
// lap3_checker: port-level assertions for the laplacian edge filter, with bind
module lap3_checker import lap3_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PIX_W-1:0]   rsp_pixel_out,
   input logic [COORD_W-1:0] rsp_out_column,
   input logic [COORD_W-1:0] rsp_out_row,
   input logic               rsp_frame_end
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out)
         && $stable(rsp_out_column) && $stable(rsp_out_row) && $stable(rsp_frame_end))
      else $error("rsp item changed while stalled");

   // only interior pixels come out
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_column != '0 && rsp_out_row != '0)
      else $error("border pixel on rsp");

   // input only backs up behind a stalled output
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req_ready low without output stall");

   // next frame needs two rows before any result
   a_frame_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_frame_end |=> !rsp_valid)
      else $error("item right after frame end");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind laplacian_3x3_edge_filter lap3_checker u_lap3_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_pixel_out  (rsp_pixel_out),
   .rsp_out_column (rsp_out_column),
   .rsp_out_row    (rsp_out_row),
   .rsp_frame_end  (rsp_frame_end)
);
